>>> rtl/slid_pkg.sv
package slid_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  entry;
    logic [COUNT_W-1:0]         count;
    logic                       last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the operation and operand of an accepted transfer
    logic exec;     // carry out the operation, or the first dump step
    logic step;     // one further dump step
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dump_more;  // the pending operation is a dump of more than one entry
    logic at_end;     // the next dump step emits the final entry
  } dp_stat_t;

endpackage

>>> rtl/slid_ctrl.sv
module slid_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  slid_pkg::cmd_t    in_cmd,
  input  logic              out_stall,
  input  slid_pkg::dp_stat_t stat,
  output logic              in_stall,
  output logic              out_valid,
  output slid_pkg::dp_cmd_t cmd
);
  import slid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DUMP = 3'b100
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  // The output register can take a new result when it is empty or being drained.
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && (in_cmd != CMD_UNUSED)) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.exec   = 1'b1;
          state_next = stat.dump_more ? S_DUMP : S_IDLE;
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          cmd.step = 1'b1;
          if (stat.at_end) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec || cmd.step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/slid_dp.sv
module slid_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  slid_pkg::in_item_t  in_data,
  input  slid_pkg::dp_cmd_t   cmd,
  output slid_pkg::dp_stat_t  stat,
  output slid_pkg::out_item_t out_data
);
  import slid_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic signed [VALUE_W-1:0] cells      [CAPACITY];
  logic signed [VALUE_W-1:0] cells_next [CAPACITY];
  logic [CW-1:0]             count;
  logic [CW-1:0]             idx;
  cmd_t                      op;
  logic signed [VALUE_W-1:0] operand;

  logic [CAPACITY-1:0] ins_sel;
  logic [CAPACITY-1:0] shl_sel;
  logic [CAPACITY-1:0] eq_sel;
  logic                full;
  logic                found;
  logic                wr_ins;
  logic                wr_del;
  logic                wr_rot;
  logic [CW-1:0]       count_inc;
  logic [CW-1:0]       count_dec;

  assign full      = (count == CW'(CAPACITY));
  assign found     = |eq_sel;
  assign count_inc = count + CW'(1);
  assign count_dec = count - CW'(1);

  assign wr_ins = cmd.exec && (op == CMD_INSERT) && !full;
  assign wr_del = cmd.exec && (op == CMD_DELETE) && found;
  assign wr_rot = (cmd.exec && (op == CMD_DUMP) && (count != '0)) || cmd.step;

  assign stat.dump_more = (op == CMD_DUMP) && (count > CW'(1));
  assign stat.at_end    = (idx == count_dec);

  // Every cell below the fill level compares its own entry with the operand. The table is sorted,
  // so the insert and shift flags form runs that end at the fill level.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (CW'(i) < count) begin
        ins_sel[i] = (cells[i] > operand);
        shl_sel[i] = (cells[i] >= operand);
        eq_sel[i]  = (cells[i] == operand);
      end else begin
        ins_sel[i] = (CW'(i) == count);
        shl_sel[i] = 1'b0;
        eq_sel[i]  = 1'b0;
      end
    end
  end

  // Each cell takes its value from itself, a neighbor, the operand or the head cell.
  always_comb begin
    int lo;
    int hi;
    for (int i = 0; i < CAPACITY; i++) begin
      lo = (i == 0) ? 0 : i - 1;
      hi = (i == CAPACITY - 1) ? i : i + 1;
      cells_next[i] = cells[i];
      if (wr_ins) begin
        if (ins_sel[i]) begin
          cells_next[i] = ((i > 0) && ins_sel[IW'(lo)]) ? cells[IW'(lo)] : operand;
        end
      end else if (wr_del) begin
        if (shl_sel[i]) begin
          cells_next[i] = cells[IW'(hi)];
        end
      end else if (wr_rot) begin
        cells_next[i] = (CW'(i) == count_dec) ? cells[0] : cells[IW'(hi)];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells[i] <= cells_next[i];
    end
    if (cmd.capture) begin
      op      <= in_data.cmd;
      operand <= in_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (wr_ins) begin
        count <= count_inc;
      end else if (wr_del) begin
        count <= count_dec;
      end
      if (cmd.exec) begin
        idx <= CW'(1);
      end else if (cmd.step) begin
        idx <= idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data.entry <= operand;
      out_data.last  <= 1'b1;
      out_data.count <= COUNT_W'(count);
      case (op)
        CMD_INSERT: begin
          if (full) begin
            out_data.status <= ST_FULL;
          end else begin
            out_data.status <= ST_OK;
            out_data.count  <= COUNT_W'(count_inc);
          end
        end
        CMD_DELETE: begin
          if (found) begin
            out_data.status <= ST_OK;
            out_data.count  <= COUNT_W'(count_dec);
          end else begin
            out_data.status <= ST_NOT_FOUND;
          end
        end
        CMD_DUMP: begin
          if (count == '0) begin
            out_data.status <= ST_EMPTY;
            out_data.entry  <= '0;
          end else begin
            out_data.status <= ST_OK;
            out_data.entry  <= cells[0];
            out_data.last   <= (count == CW'(1));
          end
        end
        default: begin
          out_data.status <= ST_OK;
        end
      endcase
    end else if (cmd.step) begin
      out_data.status <= ST_OK;
      out_data.entry  <= cells[0];
      out_data.count  <= COUNT_W'(count);
      out_data.last   <= stat.at_end;
    end
  end

endmodule

>>> rtl/sorted_list_insert_delete_unit.sv
// Insert and delete: operand capture, then one compare-and-shift pass over the cell row;
// a new transfer is taken only once that pass is done. A dump: capture, then one step
// per entry as the cell row rotates each entry into the head cell; an empty table gives
// a single ST_EMPTY result. A stalled result holds off the next step.
// Reset (rst, synchronous, active high) empties the table, idles the controller and clears
// out_valid; cell contents are kept, since entries past the fill level are never read.
module sorted_list_insert_delete_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  slid_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output slid_pkg::out_item_t out_data
);
  import slid_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // The controller sequences capture, execution and the dump steps. An input
  // transfer is taken whenever the controller is idle, even while the previous
  // result still waits in the output register; the execution step then waits
  // for that register to drain. Command code 3 is accepted and dropped.
  slid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (dp_cmd)
  );

  // The datapath holds the sorted cell row, the fill level, the dump index and
  // the output register. Every cell compares against the operand in parallel,
  // so an insert or delete completes in a single pass.
  slid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .out_data (out_data)
  );

  // At most one datapath command is issued in any cycle.
  a_one_cmd : assert property (@(posedge clk) disable iff (rst)
    $onehot0({dp_cmd.capture, dp_cmd.exec, dp_cmd.step}))
    else $error("more than one datapath command in a cycle");

  // A new result is only loaded when the output register is free.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.exec || dp_cmd.step) |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  // A transfer that carries a real command makes the block busy in the next cycle.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.cmd != CMD_UNUSED)) |=> in_stall)
    else $error("block not busy after accepting a command");

endmodule

>>> sim/tb_sorted_list_insert_delete_unit.sv
module tb_sorted_list_insert_delete_unit;
  import slid_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_ITEMS = 365;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;

  // A directed row carries the transfer to send and, where the answer is obvious,
  // the single result that it must produce.
  typedef struct {
    in_item_t  item;
    bit        has_fixed;
    out_item_t fixed_res;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Shadow copy of the sorted table, kept by the predictor.
  logic signed [VALUE_W-1:0] shadow_table [CAPACITY];
  int shadow_count = 0;

  out_item_t expected_q[$];
  out_item_t fresh_results[$];
  dir_row_t  dir_rows[$];

  int fail_count  = 0;
  int cycle_count = 0;
  bit quiet       = 1'b0;

  sorted_list_insert_delete_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Builds one result with the fill level as it stands after the operation.
  function automatic out_item_t make_result(status_t st, logic signed [VALUE_W-1:0] ent,
                                            logic lst);
    out_item_t r;
    r.status = st;
    r.entry  = ent;
    r.count  = COUNT_W'(shadow_count);
    r.last   = lst;
    return r;
  endfunction

  // Applies one command to the shadow table and leaves the results it causes in
  // fresh_results, in the order the block must emit them.
  function automatic void predict_table_op(input in_item_t item);
    int pos;
    int i;
    bit found;
    fresh_results.delete();
    case (item.cmd)
      CMD_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          fresh_results.push_back(make_result(ST_FULL, item.value, 1'b1));
        end else begin
          // The new value goes in front of the first strictly larger entry.
          pos = 0;
          while (pos < shadow_count && $signed(shadow_table[pos]) <= $signed(item.value))
            pos++;
          for (i = shadow_count; i > pos; i--) shadow_table[i] = shadow_table[i-1];
          shadow_table[pos] = item.value;
          shadow_count++;
          fresh_results.push_back(make_result(ST_OK, item.value, 1'b1));
        end
      end
      CMD_DELETE: begin
        found = 1'b0;
        pos = 0;
        while (pos < shadow_count && !found) begin
          if (shadow_table[pos] == item.value) found = 1'b1;
          else pos++;
        end
        if (!found) begin
          fresh_results.push_back(make_result(ST_NOT_FOUND, item.value, 1'b1));
        end else begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_table[i] = shadow_table[i+1];
          shadow_count--;
          fresh_results.push_back(make_result(ST_OK, item.value, 1'b1));
        end
      end
      CMD_DUMP: begin
        if (shadow_count == 0) begin
          fresh_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          for (i = 0; i < shadow_count; i++)
            fresh_results.push_back(make_result(ST_OK, shadow_table[i],
                                                i + 1 == shadow_count));
        end
      end
      default: begin
        // The spare command code is dropped without a result.
      end
    endcase
  endfunction

  function automatic void add_row(cmd_t c, logic signed [VALUE_W-1:0] v, bit fixed,
                                  status_t st, logic signed [VALUE_W-1:0] ent, int cnt);
    dir_row_t row;
    row.item.cmd          = c;
    row.item.value        = v;
    row.has_fixed         = fixed;
    row.fixed_res.status  = st;
    row.fixed_res.entry   = ent;
    row.fixed_res.count   = COUNT_W'(cnt);
    row.fixed_res.last    = 1'b1;
    dir_rows.push_back(row);
  endfunction

  // Operand mix: a narrow band around zero makes duplicates and hits on delete
  // likely, the extremes exercise the signed compare, and the rest is full range.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int sel;
    int near;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      near = $urandom_range(0, 6);
      return near - 3;
    end
    if (sel == 3) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7FFF_FFFF;
        2:       return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // Sends one transfer. Valid is lowered only when a gap is taken, so that it is
  // never dropped and raised again in the same time step. When drain_first is set,
  // the sender holds off until every outstanding result has been seen.
  task automatic send_item(input in_item_t item, input bit has_fixed,
                           input out_item_t fixed_res, input bit drain_first);
    int gap;
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(0, 99) < 9) gap++;
    end
    if (drain_first && gap == 0) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain_first) begin
        while (expected_q.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // The transfer has been taken at this edge; record what it must cause.
    predict_table_op(item);
    if (has_fixed) begin
      expected_q.push_back(fixed_res);
    end else begin
      foreach (fresh_results[i]) expected_q.push_back(fresh_results[i]);
    end
  endtask

  // The result side stalls at random, except during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 9);
  end

  // Each result transfer is checked against the oldest outstanding expectation.
  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d entry %0d count %0d last %0d",
               out_data.status, out_data.entry, out_data.count, out_data.last);
        fail_count++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_data.status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_data.status);
          fail_count++;
        end
        if (out_data.entry !== exp_res.entry) begin
          $error("entry: expected %0d, actual %0d", exp_res.entry, out_data.entry);
          fail_count++;
        end
        if (out_data.count !== exp_res.count) begin
          $error("count: expected %0d, actual %0d", exp_res.count, out_data.count);
          fail_count++;
        end
        if (out_data.last !== exp_res.last) begin
          $error("last: expected %0d, actual %0d", exp_res.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    in_item_t  item;
    out_item_t no_fixed;
    int counted;
    int roll;
    int insert_pct;
    int delete_pct;
    int k;

    no_fixed = '0;

    // Directed part. Rows with an obvious answer carry it; the others rely on
    // the predictor. The table is walked from empty to full and back a little.
    add_row(CMD_DUMP,   32'sd77,          1'b1, ST_EMPTY,     32'sd0,          0);
    add_row(CMD_DELETE, 32'sd5,           1'b1, ST_NOT_FOUND, 32'sd5,          0);
    add_row(CMD_INSERT, 32'sh7FFF_FFFF,   1'b1, ST_OK,        32'sh7FFF_FFFF,  1);
    add_row(CMD_INSERT, 32'sh8000_0000,   1'b1, ST_OK,        32'sh8000_0000,  2);
    add_row(CMD_INSERT, 32'sd0,           1'b0, ST_OK,        32'sd0,          0);
    add_row(CMD_INSERT, -32'sd1,          1'b0, ST_OK,        32'sd0,          0);
    add_row(CMD_DUMP,   32'sh5A5A_A5A5,   1'b0, ST_OK,        32'sd0,          0);
    add_row(CMD_DELETE, 32'sd12345,       1'b1, ST_NOT_FOUND, 32'sd12345,      4);
    add_row(CMD_DELETE, 32'sd0,           1'b0, ST_OK,        32'sd0,          0);
    add_row(CMD_UNUSED, 32'shFFFF_FFFF,   1'b0, ST_OK,        32'sd0,          0);
    // Fill to capacity, with repeated values among the new entries.
    for (k = 0; k < 13; k++)
      add_row(CMD_INSERT, (k % 4 == 0) ? -32'sd1 : k * 1000 - 6000, 1'b0, ST_OK, 32'sd0, 0);
    add_row(CMD_INSERT, 32'sd99,          1'b1, ST_FULL,      32'sd99,         CAPACITY);
    add_row(CMD_DUMP,   32'sd0,           1'b0, ST_OK,        32'sd0,          0);
    add_row(CMD_DELETE, 32'sh7FFF_FFFF,   1'b0, ST_OK,        32'sd0,          0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].has_fixed, dir_rows[i].fixed_res, 1'b0);

    // Random part. Phases alternate between growing and shrinking the table so
    // that it reaches both full and empty repeatedly. Spare command codes are
    // sent too but do not count toward the item total.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      quiet <= (counted >= 120 && counted < 200);
      if ((counted / 60) % 2 == 0) begin
        insert_pct = 65;
        delete_pct = 15;
      end else begin
        insert_pct = 20;
        delete_pct = 60;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5)                               item.cmd = CMD_UNUSED;
      else if (roll < 5 + insert_pct)             item.cmd = CMD_INSERT;
      else if (roll < 5 + insert_pct + delete_pct) item.cmd = CMD_DELETE;
      else                                        item.cmd = CMD_DUMP;
      // Most deletes target a value that is held, so the shift path is exercised.
      if (item.cmd == CMD_DELETE && shadow_count > 0 && $urandom_range(0, 9) < 6)
        item.value = shadow_table[$urandom_range(0, shadow_count - 1)];
      else
        item.value = pick_value();
      // While the item count stands at 250, the sender first waits for the block to drain completely.
      send_item(item, 1'b0, no_fixed, counted == 250);
      if (item.cmd != CMD_UNUSED) counted++;
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
